// ===== hw/rtl/crd_pkg.sv =====
// Shared types and constants for the coverage region detector.
`timescale 1ns / 1ps

package crd_pkg;

   localparam int POSITION_BITS = 31;
   localparam int CHROM_BITS    = 16;
   localparam int COV_BITS      = 40;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (COV_BITS > POSITION_BITS) ? COV_BITS : POSITION_BITS;

   localparam int REQ_FIELD_BITS = POSITION_BITS + COV_BITS + CHROM_BITS + POSITION_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = CHROM_BITS + 2 * POSITION_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // result queue: room for two results per request plus two still waiting
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_BITS   = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_BITS   = $clog2(RSP_FIFO_DEPTH + 1);

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [POSITION_BITS:0]   pos_ext_type;
   typedef logic [CHROM_BITS-1:0]    chrom_type;
   typedef logic [COV_BITS-1:0]      cov_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MERGE     = 2'd1,
      CSR_MIN_SIZE  = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_COVERAGE  = 1'b0,
      ACT_CHROM_END = 1'b1
   } action_type;

   typedef struct packed {
      cov_type threshold;
      pos_type merge_distance;
      pos_type min_size;
   } cfg_type;

   typedef struct packed {
      logic      action;
      pos_type   position;
      cov_type   coverage_sum;
      chrom_type chrom_id;
      pos_type   chrom_size;
   } item_type;

   typedef struct packed {
      chrom_type chrom;
      pos_type   start_pos;
      pos_type   end_pos;
      logic      last;
   } result_type;

   // up to two results from one request; push_b only together with push_a
   typedef struct packed {
      logic       push_a;
      logic       push_b;
      result_type res_a;
      result_type res_b;
   } push_type;

endpackage

// ===== hw/rtl/crd_core.sv =====
// Region tracking state and the per-request open/close/merge logic.
`timescale 1ns / 1ps

module crd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  crd_pkg::item_type item,
   input  crd_pkg::cfg_type  cfg,
   output crd_pkg::push_type push
);

   logic               open_ff, open_in;
   crd_pkg::pos_type   open_start_ff, open_start_in;
   logic               pend_valid_ff, pend_valid_in;
   crd_pkg::chrom_type pend_chrom_ff, pend_chrom_in;
   crd_pkg::pos_type   pend_start_ff, pend_start_in;
   crd_pkg::pos_type   pend_end_ff, pend_end_in;
   logic               merge_ok_ff, merge_ok_in;

   logic               is_end;
   logic               cov_hi;
   logic               do_close;
   crd_pkg::pos_type   close_end;
   logic               keep;
   logic               merge;
   logic               emit_held;
   logic               flush;
   logic               mid_valid;
   crd_pkg::chrom_type mid_chrom;
   crd_pkg::pos_type   mid_start;
   crd_pkg::pos_type   mid_end;
   logic               mid_merge_ok;
   crd_pkg::result_type held_res;
   crd_pkg::result_type flush_res;

   always_comb begin
      is_end    = (crd_pkg::action_type'(item.action) == crd_pkg::ACT_CHROM_END);
      cov_hi    = (item.coverage_sum >= cfg.threshold);
      do_close  = open_ff && (is_end || !cov_hi);
      close_end = is_end ? item.chrom_size : item.position;
      // length end - start + 1 >= min_size, done without signs
      keep = do_close &&
             ((crd_pkg::pos_ext_type'(close_end) + crd_pkg::pos_ext_type'(1)) >=
              (crd_pkg::pos_ext_type'(open_start_ff) + crd_pkg::pos_ext_type'(cfg.min_size)));
      // gap start - held end <= merge_distance; a negative gap always merges
      merge = keep && merge_ok_ff && pend_valid_ff &&
              (crd_pkg::pos_ext_type'(open_start_ff) <=
               (crd_pkg::pos_ext_type'(pend_end_ff) +
                crd_pkg::pos_ext_type'(cfg.merge_distance)));
      emit_held = keep && !merge && pend_valid_ff;

      // held region after the closing region is folded in
      mid_valid    = pend_valid_ff;
      mid_chrom    = pend_chrom_ff;
      mid_start    = pend_start_ff;
      mid_end      = pend_end_ff;
      mid_merge_ok = merge_ok_ff;
      if (keep) begin
         mid_merge_ok = 1'b1;
         mid_end      = close_end;
         if (!merge) begin
            mid_valid = 1'b1;
            mid_chrom = item.chrom_id;
            mid_start = open_start_ff;
         end
      end
      flush = is_end && mid_valid;
   end

   always_comb begin
      held_res.chrom      = pend_chrom_ff;
      held_res.start_pos  = pend_start_ff;
      held_res.end_pos    = pend_end_ff;
      held_res.last       = !flush;
      flush_res.chrom     = mid_chrom;
      flush_res.start_pos = mid_start;
      flush_res.end_pos   = mid_end;
      flush_res.last      = 1'b1;

      push.push_a = advance && (emit_held || flush);
      push.push_b = advance && emit_held && flush;
      push.res_a  = emit_held ? held_res : flush_res;
      push.res_b  = flush_res;
   end

   always_comb begin
      open_in       = open_ff;
      open_start_in = open_start_ff;
      pend_valid_in = pend_valid_ff;
      pend_chrom_in = pend_chrom_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      merge_ok_in   = merge_ok_ff;
      if (advance) begin
         pend_chrom_in = mid_chrom;
         pend_start_in = mid_start;
         pend_end_in   = mid_end;
         if (is_end) begin
            open_in       = 1'b0;
            pend_valid_in = 1'b0;
            merge_ok_in   = 1'b0;
         end else begin
            pend_valid_in = mid_valid;
            merge_ok_in   = mid_merge_ok;
            if (cov_hi) begin
               if (!open_ff) begin
                  open_in       = 1'b1;
                  open_start_in = item.position;
               end
            end else begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         open_start_ff <= '0;
         pend_valid_ff <= 1'b0;
         pend_chrom_ff <= '0;
         pend_start_ff <= '0;
         pend_end_ff   <= '0;
         merge_ok_ff   <= 1'b0;
      end else begin
         open_ff       <= open_in;
         open_start_ff <= open_start_in;
         pend_valid_ff <= pend_valid_in;
         pend_chrom_ff <= pend_chrom_in;
         pend_start_ff <= pend_start_in;
         pend_end_ff   <= pend_end_in;
         merge_ok_ff   <= merge_ok_in;
      end
   end

   // merging is only ever enabled by a kept region, which is then held
   a_merge_needs_held: assert property (@(posedge clock) disable iff (reset)
      merge_ok_ff |-> pend_valid_ff)
      else $error("merge enabled with no held region");

   // a chromosome end leaves nothing open or held
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_end) |=> (!open_ff && !pend_valid_ff && !merge_ok_ff))
      else $error("state left over after chromosome end");

endmodule

// ===== hw/rtl/crd_rsp_fifo.sv =====
// Small result queue taking up to two results a cycle and giving one.
`timescale 1ns / 1ps

module crd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  crd_pkg::push_type    push,
   output logic                 room_two,
   output logic                 rsp_valid,
   output crd_pkg::result_type  rsp_res,
   input  logic                 rsp_ready
);

   crd_pkg::result_type entry_ff [crd_pkg::RSP_FIFO_DEPTH];
   logic [crd_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crd_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crd_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [crd_pkg::RSP_PTR_BITS-1:0] wr_ptr_next;
   logic pop;

   always_comb begin
      rsp_valid   = (count_ff != '0);
      rsp_res     = entry_ff[rd_ptr_ff];
      room_two    = (count_ff <= crd_pkg::RSP_CNT_BITS'(crd_pkg::RSP_FIFO_DEPTH - 2));
      pop         = rsp_valid && rsp_ready;
      wr_ptr_next = wr_ptr_ff + crd_pkg::RSP_PTR_BITS'(1);
      wr_ptr_in   = wr_ptr_ff + crd_pkg::RSP_PTR_BITS'(push.push_a)
                              + crd_pkg::RSP_PTR_BITS'(push.push_b);
      rd_ptr_in   = rd_ptr_ff + crd_pkg::RSP_PTR_BITS'(pop);
      count_in    = count_ff + crd_pkg::RSP_CNT_BITS'(push.push_a)
                             + crd_pkg::RSP_CNT_BITS'(push.push_b)
                             - crd_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         entry_ff[wr_ptr_ff] <= push.res_a;
      end
      if (push.push_b) begin
         entry_ff[wr_ptr_next] <= push.res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push_a |-> room_two)
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crd_pkg::RSP_CNT_BITS'(crd_pkg::RSP_FIFO_DEPTH))
      else $error("result queue count out of range");

endmodule

// ===== hw/rtl/coverage_region_detector.sv =====
// Top level of the coverage region detector: ports, config registers, input stage.
`timescale 1ns / 1ps

// Coverage region detector.
// Request channel (req_*): one request per genome position, or a chromosome
//   end marker (req_tuser = 1). A request is taken when req_tvalid and
//   req_tready are both high.
// Response channel (rsp_*): one response per finished region, in order;
//   rsp_tlast marks the final response caused by a request (at most two).
// Config port (csr_*): threshold, merge distance and min size, written with
//   csr_we; change them only while the block is idle. Index 3 is ignored.
// Path: a request is held in the input register, then the region logic
//   writes its responses to a four-entry queue, whose head drives rsp_tvalid.
// Throughput: one request per cycle while the queue has room, limited by the
//   response port at one response per cycle; requests that emit two
//   responses drain through the single queue read port.
// Stalls: with rsp_tready low the queue fills; the input register is then
//   held and req_tready drops once the queue has no room for two responses.
// Reset: synchronous, clears the config to threshold 0, merge distance 0,
//   min size 1, drops all region state and empties the queue.

module coverage_region_detector (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [30:0] position, [70:31] coverage_sum, [86:71] chrom_id,
   // [117:87] chrom_size, rest zero
   input  logic [crd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [0] action
   input  logic                               req_tuser,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] out_chrom, [46:16] out_start, [77:47] out_end, rest zero
   output logic [crd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   // config
   input  logic                               csr_we,
   input  logic [crd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [crd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int PB = crd_pkg::POSITION_BITS;
   localparam int CB = crd_pkg::COV_BITS;
   localparam int HB = crd_pkg::CHROM_BITS;

   crd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   crd_pkg::item_type   in_item_ff, in_item_in;
   crd_pkg::item_type   req_item;
   crd_pkg::push_type   push;
   crd_pkg::result_type rsp_res;
   logic                room_two;
   logic                advance;
   logic                req_take;

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (crd_pkg::csr_index_type'(csr_index))
            crd_pkg::CSR_THRESHOLD: cfg_in.threshold      = csr_wdata[CB-1:0];
            crd_pkg::CSR_MERGE:     cfg_in.merge_distance = csr_wdata[PB-1:0];
            crd_pkg::CSR_MIN_SIZE:  cfg_in.min_size       = csr_wdata[PB-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold      <= '0;
         cfg_ff.merge_distance <= '0;
         cfg_ff.min_size       <= crd_pkg::pos_type'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack request
   always_comb begin
      req_item.action       = req_tuser;
      req_item.position     = req_tdata[PB-1:0];
      req_item.coverage_sum = req_tdata[PB+CB-1:PB];
      req_item.chrom_id     = req_tdata[PB+CB+HB-1:PB+CB];
      req_item.chrom_size   = req_tdata[2*PB+CB+HB-1:PB+CB+HB];
   end

   // input register: drains into the region logic when the queue has room
   always_comb begin
      advance     = in_valid_ff && room_two;
      req_tready  = !in_valid_ff || advance;
      req_take    = req_tvalid && req_tready;
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_item_in  = req_take ? req_item : in_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   crd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .push    (push)
   );

   crd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .rsp_valid (rsp_tvalid),
      .rsp_res   (rsp_res),
      .rsp_ready (rsp_tready)
   );

   // pack response, zero filled to whole bytes
   assign rsp_tdata = crd_pkg::RSP_TDATA_BITS'({rsp_res.end_pos, rsp_res.start_pos,
                                                rsp_res.chrom});
   assign rsp_tlast = rsp_res.last;

endmodule

// ===== sim/tb_coverage_region_detector.sv =====
// Self-checking testbench for the coverage region detector: directed and random streams.
`timescale 1ns / 1ps

module tb_coverage_region_detector;

   localparam int CYCLE_LIMIT  = 200000;
   // pipeline is the input register and region logic plus the result queue; a
   // request that emits nothing is gone well before this drain wait ends
   localparam int DRAIN_CYCLES = 12;
   localparam int REQ_PAD      = crd_pkg::REQ_TDATA_BITS - crd_pkg::REQ_FIELD_BITS;
   // index 3 has no register behind it, writes there must be dropped
   localparam logic [crd_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam crd_pkg::cov_type COV_MAX = '1;
   localparam crd_pkg::pos_type POS_MAX = '1;

   logic clock;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // [30:0] position, [70:31] coverage_sum, [86:71] chrom_id, [117:87] chrom_size
   logic [crd_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   // [0] action
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // [15:0] out_chrom, [46:16] out_start, [77:47] out_end
   logic [crd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_we = 1'b0;
   logic [crd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [crd_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   coverage_region_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle rates in percent, changed between traffic phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // predictor copy of the config registers (reset values)
   crd_pkg::cov_type cfg_threshold = '0;
   crd_pkg::pos_type cfg_merge     = '0;
   crd_pkg::pos_type cfg_min_size  = 31'd1;

   // predictor copy of the region state
   logic               region_open  = 1'b0;
   crd_pkg::pos_type   region_start = '0;
   logic               held_valid   = 1'b0;
   crd_pkg::chrom_type held_chrom   = '0;
   crd_pkg::pos_type   held_start   = '0;
   crd_pkg::pos_type   held_end     = '0;
   logic               merge_ok     = 1'b0;

   // regions the block still owes us, oldest first
   crd_pkg::result_type expected_regions[$];

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic crd_pkg::cov_type rand40();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[39:0];
   endfunction

   function automatic crd_pkg::item_type random_item();
      crd_pkg::item_type it;
      it.action       = 1'($urandom_range(1));
      it.position     = crd_pkg::pos_type'($urandom);
      it.coverage_sum = rand40();
      it.chrom_id     = crd_pkg::chrom_type'($urandom);
      it.chrom_size   = crd_pkg::pos_type'($urandom);
      return it;
   endfunction

   // chrom_size is don't-care on a coverage request, so it stays random
   function automatic crd_pkg::item_type coverage_at(crd_pkg::pos_type pos,
                                                     crd_pkg::cov_type cov,
                                                     crd_pkg::chrom_type chrom);
      crd_pkg::item_type it;
      it              = random_item();
      it.action       = crd_pkg::ACT_COVERAGE;
      it.position     = pos;
      it.coverage_sum = cov;
      it.chrom_id     = chrom;
      return it;
   endfunction

   // position and coverage are don't-care on a chromosome end
   function automatic crd_pkg::item_type chrom_end(crd_pkg::chrom_type chrom,
                                                   crd_pkg::pos_type size);
      crd_pkg::item_type it;
      it            = random_item();
      it.action     = crd_pkg::ACT_CHROM_END;
      it.chrom_id   = chrom;
      it.chrom_size = size;
      return it;
   endfunction

   function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Closing a region: drop if too short, else merge into the held region or
   // push the held one out and hold the new one. Length and gap are signed.
   task automatic close_region(input crd_pkg::pos_type s, input crd_pkg::pos_type e,
                               input crd_pkg::chrom_type chrom,
                               ref crd_pkg::result_type found[$]);
      longint span;
      longint gap;
      span = longint'(e) - longint'(s) + 1;
      gap  = longint'(s) - longint'(held_end);
      if (span < longint'(cfg_min_size))
         return;
      if (merge_ok && held_valid && gap <= longint'(cfg_merge)) begin
         held_end = e;
      end else begin
         if (held_valid)
            found.insert(found.size(), '{chrom: held_chrom, start_pos: held_start,
                                         end_pos: held_end, last: 1'b0});
         held_valid = 1'b1;
         held_chrom = chrom;
         held_start = s;
         held_end   = e;
      end
      merge_ok = 1'b1;
   endtask

   task automatic predict_regions(input crd_pkg::item_type it);
      crd_pkg::result_type found[$];
      if (it.action == crd_pkg::ACT_COVERAGE) begin
         if (it.coverage_sum >= cfg_threshold) begin
            if (!region_open) begin
               region_open  = 1'b1;
               region_start = it.position;
            end
         end else if (region_open) begin
            // the falling position itself becomes the region end
            close_region(region_start, it.position, it.chrom_id, found);
            region_open = 1'b0;
         end
      end else begin
         if (region_open)
            close_region(region_start, it.chrom_size, it.chrom_id, found);
         region_open = 1'b0;
         merge_ok    = 1'b0;
         if (held_valid)
            found.insert(found.size(), '{chrom: held_chrom, start_pos: held_start,
                                         end_pos: held_end, last: 1'b0});
         held_valid = 1'b0;
      end
      if (found.size() != 0)
         found[found.size()-1].last = 1'b1;
      foreach (found[k])
         expected_regions.insert(expected_regions.size(), found[k]);
   endtask

   // Response checker: every accepted response against the oldest expected region.
   always @(posedge clock) begin
      crd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_regions.size() == 0) begin
            $error("unexpected region: chrom %0d start %0d end %0d",
                   rsp_tdata[15:0], rsp_tdata[46:16], rsp_tdata[77:47]);
            fail_count++;
         end else begin
            want = expected_regions.pop_front();
            check_field("out_chrom", 64'(want.chrom), 64'(rsp_tdata[15:0]));
            check_field("out_start", 64'(want.start_pos), 64'(rsp_tdata[46:16]));
            check_field("out_end", 64'(want.end_pos), 64'(rsp_tdata[77:47]));
            check_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
            check_field("tdata padding", '0,
                        64'(rsp_tdata[crd_pkg::RSP_TDATA_BITS-1:crd_pkg::RSP_FIELD_BITS]));
         end
      end
   end

   // Called at a falling edge, returns at a falling edge with tvalid still
   // high, so back-to-back requests never lower and raise it in one step.
   task automatic send_request(input crd_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {{REQ_PAD{1'b0}}, it.chrom_size, it.chrom_id,
                     it.coverage_sum, it.position};
      do @(posedge clock); while (!req_tready);
      predict_regions(it);
      @(negedge clock);
   endtask

   // drain: all expected regions out, then time for silent requests to retire
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (expected_regions.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one write to the dead index first, then the three real registers
   task automatic apply_config(input logic [39:0] thr, input logic [39:0] merge_word,
                               input logic [39:0] min_word);
      logic [crd_pkg::CSR_INDEX_BITS-1:0] idx [4];
      logic [crd_pkg::CSR_DATA_BITS-1:0]  val [4];
      idx = '{CSR_UNUSED, crd_pkg::CSR_THRESHOLD, crd_pkg::CSR_MERGE,
              crd_pkg::CSR_MIN_SIZE};
      val = '{rand40(), thr, merge_word, min_word};
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         case (idx[k])
            crd_pkg::CSR_THRESHOLD: cfg_threshold = val[k];
            crd_pkg::CSR_MERGE:     cfg_merge     = val[k][crd_pkg::POSITION_BITS-1:0];
            crd_pkg::CSR_MIN_SIZE:  cfg_min_size  = val[k][crd_pkg::POSITION_BITS-1:0];
            default: ;
         endcase
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Reset config: threshold 0 means every sample is at or above it, so a
   // region only closes at the chromosome end.
   task automatic test_reset_defaults();
      send_request(coverage_at(31'd10, '0, 16'd1));
      send_request(chrom_end(16'd1, 31'd100));
      // nothing open or held: no response
      send_request(chrom_end(16'd1, 31'd100));
   endtask

   // Threshold 1.5 (32.8), merge distance 5, min size 3.
   task automatic test_region_rules();
      wait_quiet();
      apply_config(40'h180, 40'd5, 40'd3);
      send_request(coverage_at(31'd100, 40'h180, 16'd2));  // equal opens
      send_request(coverage_at(31'd101, 40'h17f, 16'd2));  // length 2, dropped
      send_request(coverage_at(31'd110, COV_MAX, 16'd2));
      send_request(coverage_at(31'd115, '0, 16'd2));       // held 110..115
      send_request(coverage_at(31'd118, 40'h200, 16'd2));
      send_request(coverage_at(31'd120, '0, 16'd2));       // gap 3, merged
      send_request(coverage_at(31'd130, 40'h200, 16'd2));
      send_request(coverage_at(31'd133, '0, 16'd2));       // gap 10, pushes 110..120
      send_request(coverage_at(31'd140, 40'h200, 16'd2));
      // closes at 150, pushes 130..133, then flushes 140..150
      send_request(chrom_end(16'd2, 31'd150));
   endtask

   task automatic test_corner_cases();
      // region going backwards: negative gap always merges
      send_request(coverage_at(31'd200, 40'h300, 16'd3));
      send_request(coverage_at(31'd205, 40'h0ff, 16'd3));
      send_request(coverage_at(31'd190, 40'h300, 16'd3));
      send_request(coverage_at(31'd195, 40'h0ff, 16'd3));
      // chromosome end before the open start: negative length, dropped
      send_request(coverage_at(31'd500, 40'h300, 16'd4));
      send_request(chrom_end(16'd4, 31'd400));
      // chromosome id changes with no end request; merge still applies
      send_request(coverage_at(31'd10, 40'h300, 16'd5));
      send_request(coverage_at(31'd20, '0, 16'd5));
      send_request(coverage_at(31'd22, 40'h300, 16'd6));
      send_request(coverage_at(31'd30, '0, 16'd6));
      send_request(chrom_end(16'd6, 31'd999));

      // top threshold, widest merge, zero min size
      wait_quiet();
      apply_config(COV_MAX, '1, 40'd0);
      send_request(coverage_at(31'd1000, COV_MAX, 16'd7));
      // length 0 kept
      send_request(coverage_at(31'd999, COV_MAX - crd_pkg::cov_type'(1), 16'd7));
      send_request(coverage_at(31'd2000, COV_MAX, 16'd7));
      send_request(coverage_at(31'd1990, '0, 16'd7));           // length -9 dropped
      send_request(coverage_at(POS_MAX, COV_MAX, 16'd7));
      send_request(chrom_end(16'hffff, POS_MAX));

      // largest min size: only a full-span region survives
      wait_quiet();
      apply_config(COV_MAX, '1, 40'h7fff_ffff);
      send_request(coverage_at(31'd0, COV_MAX, 16'hffff));
      send_request(chrom_end(16'hffff, POS_MAX));
   endtask

   function automatic crd_pkg::cov_type near_threshold(logic above);
      int d;
      d = $urandom_range(3);
      if (above)
         return (cfg_threshold > COV_MAX - crd_pkg::cov_type'(d))
                ? COV_MAX : cfg_threshold + crd_pkg::cov_type'(d);
      if ($urandom_range(7) == 0 || cfg_threshold <= crd_pkg::cov_type'(d + 1))
         return '0;
      return cfg_threshold - crd_pkg::cov_type'(d + 1);
   endfunction

   // Mostly well-formed chromosome walks: positions step forward, coverage
   // hovers around the threshold, and chromosome ends come every dozen or so.
   // The rest is noise, backward steps and id changes mid-region.
   task automatic random_stream(input int count);
      crd_pkg::chrom_type chrom;
      crd_pkg::pos_type   pos;
      logic               above;
      crd_pkg::item_type  it;
      int                 pick;
      chrom = crd_pkg::chrom_type'($urandom);
      pos   = crd_pkg::pos_type'($urandom);
      above = 1'b0;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         it   = random_item();
         if (pick < 8) begin
            // pure noise, fields as drawn
         end else if (pick < 16) begin
            it = chrom_end(chrom, ($urandom_range(3) == 0)
                                  ? crd_pkg::pos_type'($urandom)
                                  : crd_pkg::pos_type'(pos + $urandom_range(40)));
            if ($urandom_range(3) != 0)
               chrom = crd_pkg::chrom_type'($urandom);
            pos = crd_pkg::pos_type'($urandom);
         end else begin
            if ($urandom_range(99) < 35)
               above = ~above;
            if (pick < 19)
               pos = crd_pkg::pos_type'(pos - $urandom_range(1, 30));
            else
               pos = crd_pkg::pos_type'(pos + $urandom_range(1, 4));
            if (pick == 19)
               chrom = crd_pkg::chrom_type'($urandom);
            it = coverage_at(pos, near_threshold(above), chrom);
         end
         send_request(it);
      end
   endtask

   task automatic test_random_traffic();
      logic [39:0] thr;
      logic [39:0] merge_word;
      logic [39:0] min_word;
      for (int blk = 0; blk < 3; blk++) begin
         wait_quiet();
         case ($urandom_range(9))
            0:       thr = '0;
            1:       thr = COV_MAX;
            default: thr = rand40();
         endcase
         // upper bits of the narrow registers carry junk that must be masked
         merge_word = rand40();
         case ($urandom_range(9))
            6, 7:    merge_word[30:0] = '0;
            8:       merge_word[30:0] = '1;
            9:       merge_word[30:0] = 31'($urandom);
            default: merge_word[30:0] = 31'($urandom_range(12));
         endcase
         min_word = rand40();
         case ($urandom_range(9))
            6:       min_word[30:0] = '0;
            7:       min_word[30:0] = 31'($urandom_range(7, 30));
            8:       min_word[30:0] = 31'($urandom);
            9:       min_word[30:0] = '1;
            default: min_word[30:0] = 31'($urandom_range(1, 6));
         endcase
         apply_config(thr, merge_word, min_word);
         random_stream(44);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 52;
      test_reset_defaults();
      test_region_rules();
      test_corner_cases();
      test_random_traffic();

      send_idle_pct = 52;
      recv_idle_pct = 35;
      test_random_traffic();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic();

      wait_quiet();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== coverage_region_detector.f =====
hw/rtl/crd_pkg.sv
hw/rtl/crd_core.sv
hw/rtl/crd_rsp_fifo.sv
hw/rtl/coverage_region_detector.sv
sim/tb_coverage_region_detector.sv
